FILE: src/htra_pkg.sv
// ============================================================================
// Handle table allocator package
// Shared sizes, operation and status codes, and the controller command bundle.
// ============================================================================
package htra_pkg;

    // Table geometry and stored field widths.
    localparam int SLOTS        = 256;
    localparam int SLOT_AW      = $clog2(SLOTS);
    localparam int CNT_W        = SLOT_AW + 1;
    localparam int PAYLOAD_BITS = 32;
    localparam int REF_BITS     = 16;

    // Port field widths.
    localparam int KIND_W    = 3;
    localparam int HANDLE_W  = 8;
    localparam int TYPE_W    = 8;
    localparam int PAY_IN_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Operation codes carried on s_tuser.
    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 3'd4;

    // Result status codes carried on m_tuser.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input item and launch the memory reads
        logic commit;   // write back state and load the result register
    } htra_cmd_t;

endpackage

FILE: src/handle_table_refcount_allocator.sv
// ============================================================================
// Handle table allocator with reference counts
// Allocates slot handles from a free-index FIFO or a high-water mark and
// keeps a type tag, payload word and saturating reference count per slot.
// ============================================================================
// Each operation first accepts the item and reads the slot memories and the
// free-index FIFO, then writes back and loads the result register. The block
// takes one item at a time: it accepts no new item until the last one has
// been written back, since the registered read must finish before each
// write-back. A new item can be accepted while the previous result is still
// waiting on the master side. No clearing pass is needed after reset.
module handle_table_refcount_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // handle[7:0], type_tag[15:8], payload[47:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // handle_out[7:0], payload_out[39:8], type_out[47:40]
    output logic [1:0]  m_tuser    // status[1:0]
);

    htra_pkg::htra_cmd_t cmd;

    logic [htra_pkg::STATUS_W-1:0] out_status;
    logic [htra_pkg::HANDLE_W-1:0] out_handle;
    logic [htra_pkg::PAY_IN_W-1:0] out_payload;
    logic [htra_pkg::TYPE_W-1:0]   out_type;

    // Sequencer.
    htra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Table storage and operation logic.
    htra_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_kind     (s_tuser),
        .in_handle   (s_tdata[7:0]),
        .in_tag      (s_tdata[15:8]),
        .in_payload  (s_tdata[47:16]),
        .out_status  (out_status),
        .out_handle  (out_handle),
        .out_payload (out_payload),
        .out_type    (out_type)
    );

    // Pack the result.
    assign m_tdata = {out_type, out_payload, out_handle};
    assign m_tuser = out_status;

endmodule

FILE: src/htra_ctrl.sv
// ============================================================================
// Handle table allocator controller
// Two-state sequencer: accept an item, then execute it once the result
// register is free. Also owns the result valid flag.
// ============================================================================
module htra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output htra_pkg::htra_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag: set on commit, cleared when the transfer completes.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/htra_datapath.sv
// ============================================================================
// Handle table allocator datapath
// Slot memories, occupied bits, free-index FIFO, high-water mark and the
// result register. Reads launch on capture, write-back happens on commit.
// ============================================================================
module htra_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  htra_pkg::htra_cmd_t                   cmd,
    input  logic [htra_pkg::KIND_W-1:0]           in_kind,
    input  logic [htra_pkg::HANDLE_W-1:0]         in_handle,
    input  logic [htra_pkg::TYPE_W-1:0]           in_tag,
    input  logic [htra_pkg::PAY_IN_W-1:0]         in_payload,
    output logic [htra_pkg::STATUS_W-1:0]         out_status,
    output logic [htra_pkg::HANDLE_W-1:0]         out_handle,
    output logic [htra_pkg::PAY_IN_W-1:0]         out_payload,
    output logic [htra_pkg::TYPE_W-1:0]           out_type
);

    localparam int AW = htra_pkg::SLOT_AW;
    localparam int CW = htra_pkg::CNT_W;
    localparam int PW = htra_pkg::PAYLOAD_BITS;
    localparam int RW = htra_pkg::REF_BITS;
    localparam logic [RW-1:0] REF_MAX = {RW{1'b1}};

    // Memories.
    logic [PW-1:0]                   payload_mem [htra_pkg::SLOTS];
    logic [htra_pkg::TYPE_W-1:0]     type_mem    [htra_pkg::SLOTS];
    logic [RW-1:0]                   ref_mem     [htra_pkg::SLOTS];
    logic [AW-1:0]                   fifo_mem    [htra_pkg::SLOTS];

    // Registered read data.
    logic [PW-1:0]               pay_rd_reg;
    logic [htra_pkg::TYPE_W-1:0] type_rd_reg;
    logic [RW-1:0]               ref_rd_reg;
    logic [AW-1:0]               fifo_rd_reg;

    // Latched item.
    logic [htra_pkg::KIND_W-1:0]   kind_reg;
    logic [htra_pkg::HANDLE_W-1:0] handle_reg;
    logic [htra_pkg::TYPE_W-1:0]   tag_reg;
    logic [PW-1:0]                 payload_reg;

    // Control state.
    logic [htra_pkg::SLOTS-1:0] occ_reg, occ_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] hw_reg, hw_next;

    // Result register.
    logic [htra_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [htra_pkg::HANDLE_W-1:0] hout_reg, hout_next;
    logic [htra_pkg::PAY_IN_W-1:0] pout_reg, pout_next;
    logic [htra_pkg::TYPE_W-1:0]   tout_reg, tout_next;

    // Write strobes for the memories.
    logic          slot_we;
    logic          ref_we;
    logic [AW-1:0] slot_wa;
    logic [RW-1:0] ref_wd;
    logic          fifo_we;

    logic [AW-1:0] h_idx;
    logic          below;
    logic          occ_h;
    logic          do_free;

    assign h_idx = AW'(handle_reg);
    assign below = CW'(handle_reg) < hw_reg;
    assign occ_h = occ_reg[h_idx];

    // Latch the accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= in_kind;
            handle_reg  <= in_handle;
            tag_reg     <= in_tag;
            payload_reg <= PW'(in_payload);
        end
    end

    // Execute the operation and compute write-back and result values.
    always_comb begin
        occ_next    = occ_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        hw_next     = hw_reg;
        status_next = htra_pkg::ST_OK;
        hout_next   = handle_reg;
        pout_next   = '0;
        tout_next   = '0;
        slot_we     = 1'b0;
        ref_we      = 1'b0;
        slot_wa     = h_idx;
        ref_wd      = '0;
        do_free     = 1'b0;

        unique case (kind_reg)
            htra_pkg::KIND_ADD: begin
                if (count_reg != '0) begin
                    slot_wa    = fifo_rd_reg;
                    head_next  = AW'(head_reg + 1'b1);
                    count_next = count_reg - 1'b1;
                    slot_we    = 1'b1;
                end else if (hw_reg < CW'(htra_pkg::SLOTS)) begin
                    slot_wa = AW'(hw_reg);
                    hw_next = hw_reg + 1'b1;
                    slot_we = 1'b1;
                end else begin
                    status_next = htra_pkg::ST_FULL;
                end
                if (slot_we) begin
                    ref_we            = 1'b1;
                    ref_wd            = '0;
                    occ_next[slot_wa] = 1'b1;
                    hout_next         = htra_pkg::HANDLE_W'(slot_wa);
                end
            end
            htra_pkg::KIND_DELETE: begin
                if (!below) begin
                    status_next = htra_pkg::ST_INVALID;
                end else if (occ_h) begin
                    do_free = 1'b1;
                end
            end
            htra_pkg::KIND_GET: begin
                if (!below || !occ_h) begin
                    status_next = htra_pkg::ST_EMPTY;
                end else begin
                    if (ref_rd_reg != REF_MAX) begin
                        ref_we = 1'b1;
                        ref_wd = ref_rd_reg + 1'b1;
                    end
                    pout_next = htra_pkg::PAY_IN_W'(pay_rd_reg);
                    tout_next = type_rd_reg;
                end
            end
            htra_pkg::KIND_RELEASE: begin
                if (!below || !occ_h) begin
                    status_next = htra_pkg::ST_EMPTY;
                end else if (ref_rd_reg < RW'(2)) begin
                    ref_we  = 1'b1;
                    ref_wd  = '0;
                    do_free = 1'b1;
                end else begin
                    ref_we = 1'b1;
                    ref_wd = ref_rd_reg - 1'b1;
                end
            end
            htra_pkg::KIND_CHECK: begin
                status_next = below ? htra_pkg::ST_OK : htra_pkg::ST_INVALID;
            end
            default: begin
                status_next = htra_pkg::ST_INVALID;
            end
        endcase

        // Free the addressed slot and queue its index.
        fifo_we = 1'b0;
        if (do_free) begin
            occ_next[h_idx] = 1'b0;
            if (count_reg < CW'(htra_pkg::SLOTS)) begin
                fifo_we    = 1'b1;
                tail_next  = AW'(tail_reg + 1'b1);
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Slot payload and type memories.
    always_ff @(posedge aclk) begin
        if (cmd.commit && slot_we) begin
            payload_mem[slot_wa] <= payload_reg;
            type_mem[slot_wa]    <= tag_reg;
        end
        if (cmd.capture) begin
            pay_rd_reg  <= payload_mem[AW'(in_handle)];
            type_rd_reg <= type_mem[AW'(in_handle)];
        end
    end

    // Reference count memory.
    always_ff @(posedge aclk) begin
        if (cmd.commit && ref_we) begin
            ref_mem[slot_wa] <= ref_wd;
        end
        if (cmd.capture) begin
            ref_rd_reg <= ref_mem[AW'(in_handle)];
        end
    end

    // Free-index FIFO memory.
    always_ff @(posedge aclk) begin
        if (cmd.commit && fifo_we) begin
            fifo_mem[tail_reg] <= h_idx;
        end
        if (cmd.capture) begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    // Control state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            hw_reg    <= '0;
        end else if (cmd.commit) begin
            occ_reg   <= occ_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            hw_reg    <= hw_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg <= status_next;
            hout_reg   <= hout_next;
            pout_reg   <= pout_next;
            tout_reg   <= tout_next;
        end
    end

    assign out_status  = status_reg;
    assign out_handle  = hout_reg;
    assign out_payload = pout_reg;
    assign out_type    = tout_reg;

endmodule
